// ===== sv/b64sc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64sc_pkg: shared types and constants of the Base64 stream codec
// Item structs, the group transaction type passed from the front end to
// the serializer, register indexes and the alphabet mapping functions.
// ----------------------------------------------------------------------------
package b64sc_pkg;

	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 7;

	localparam logic [CFG_INDEX_W-1:0] REG_DIRECTION = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_ALPHABET  = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_PAD       = 2'd2;

	localparam logic [6:0] PAD_RESET = 7'd61;

	localparam logic [7:0] CH_UPPER_A = 8'h41;
	localparam logic [7:0] CH_UPPER_Z = 8'h5A;
	localparam logic [7:0] CH_LOWER_A = 8'h61;
	localparam logic [7:0] CH_LOWER_Z = 8'h7A;
	localparam logic [7:0] CH_DIGIT_0 = 8'h30;
	localparam logic [7:0] CH_DIGIT_9 = 8'h39;
	localparam logic [7:0] CH_PLUS    = 8'h2B;
	localparam logic [7:0] CH_SLASH   = 8'h2F;
	localparam logic [7:0] CH_MINUS   = 8'h2D;
	localparam logic [7:0] CH_UNDER   = 8'h5F;
	localparam logic [7:0] CH_BANG    = 8'h21;
	localparam logic [7:0] CH_DOT     = 8'h2E;
	localparam logic [7:0] CH_COLON   = 8'h3A;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       in_last;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       out_last;
	} out_item_t;

	// One group of results: up to four bytes, the count less one, and
	// whether the final byte of the group ends the message.
	typedef struct packed {
		logic [3:0][7:0] chars;
		logic [1:0]      n_m1;
		logic            last;
	} job_t;

	function automatic logic [7:0] sym62_of(input logic [2:0] variant);
		logic [7:0] ch;
		unique case (variant)
			3'd1: ch = CH_MINUS;
			3'd2: ch = CH_BANG;
			3'd3: ch = CH_DOT;
			3'd4: ch = CH_UNDER;
			3'd5: ch = CH_DOT;
			default: ch = CH_PLUS;
		endcase
		return ch;
	endfunction

	function automatic logic [7:0] sym63_of(input logic [2:0] variant);
		logic [7:0] ch;
		unique case (variant)
			3'd1: ch = CH_UNDER;
			3'd2: ch = CH_MINUS;
			3'd3: ch = CH_MINUS;
			3'd4: ch = CH_COLON;
			3'd5: ch = CH_UNDER;
			default: ch = CH_SLASH;
		endcase
		return ch;
	endfunction

	function automatic logic [7:0] sym_of(input logic [5:0] v, input logic [2:0] variant);
		logic [7:0] ch;
		if (v < 6'd26) begin
			ch = CH_UPPER_A + {2'b00, v};
		end else if (v < 6'd52) begin
			ch = CH_LOWER_A + {2'b00, v} - 8'd26;
		end else if (v < 6'd62) begin
			ch = CH_DIGIT_0 + {2'b00, v} - 8'd52;
		end else if (v == 6'd62) begin
			ch = sym62_of(variant);
		end else begin
			ch = sym63_of(variant);
		end
		return ch;
	endfunction

	// Characters outside the alphabet decode as zero.
	function automatic logic [5:0] value_of(input logic [7:0] ch, input logic [2:0] variant);
		logic [5:0] v;
		priority if (ch >= CH_UPPER_A && ch <= CH_UPPER_Z) begin
			v = 6'(ch - CH_UPPER_A);
		end else if (ch >= CH_LOWER_A && ch <= CH_LOWER_Z) begin
			v = 6'(ch - CH_LOWER_A + 8'd26);
		end else if (ch >= CH_DIGIT_0 && ch <= CH_DIGIT_9) begin
			v = 6'(ch - CH_DIGIT_0 + 8'd52);
		end else if (ch == sym63_of(variant)) begin
			v = 6'd63;
		end else if (ch == sym62_of(variant)) begin
			v = 6'd62;
		end else begin
			v = 6'd0;
		end
		return v;
	endfunction

endpackage

// ===== sv/b64sc_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64sc_front: input acceptance, grouping and symbol mapping
// Holds the configuration registers and the partial group, and turns each
// completed group into one group transaction for the result queue.
// ----------------------------------------------------------------------------
module b64sc_front
	import b64sc_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	input  logic                   in_valid,
	input  in_item_t               in_data,
	input  logic                   q_full,
	output logic                   push,
	output job_t                   push_job
);

	logic        dir_q;
	logic [2:0]  variant_q;
	logic [6:0]  pad_q;
	logic [23:0] grp_q;
	logic [1:0]  cnt_q;
	logic        ended_q;

	logic        in_fire;
	logic [7:0]  b;
	logic        last;

	logic [23:0] enc_bits, enc_aligned;
	logic [2:0]  enc_c;
	logic        enc_fire;
	logic [3:0][7:0] enc_chars;

	logic        is_pad;
	logic [23:0] dec_bits, fl_bits, fl_aligned;
	logic [2:0]  dec_c, fl_c, fl_n;
	logic [3:0][7:0] fl_chars;

	logic [23:0] grp_n;
	logic [1:0]  cnt_n;
	logic        ended_n;

	assign in_fire = in_valid && !q_full;
	assign b       = in_data.in_byte;
	assign last    = in_data.in_last;

	always_comb begin
		enc_bits = {grp_q[15:0], b};
		enc_c    = {1'b0, cnt_q} + 3'd1;
		enc_fire = (enc_c == 3'd3) || last;
		unique case (enc_c)
			3'd1: enc_aligned = enc_bits << 16;
			3'd2: enc_aligned = enc_bits << 8;
			default: enc_aligned = enc_bits;
		endcase
		// Positions past the gathered bytes carry the pad character.
		for (int k = 0; k < 4; k++) begin
			if (3'(k) <= enc_c) begin
				enc_chars[k] = sym_of(enc_aligned[23-6*k -: 6], variant_q);
			end else begin
				enc_chars[k] = {1'b0, pad_q};
			end
		end
	end

	always_comb begin
		is_pad   = (b == {1'b0, pad_q});
		dec_bits = {grp_q[17:0], value_of(b, variant_q)};
		dec_c    = {1'b0, cnt_q} + 3'd1;
		// A pad flushes what is already held; otherwise the new character joins.
		if (is_pad) begin
			fl_bits = grp_q;
			fl_c    = {1'b0, cnt_q};
		end else begin
			fl_bits = dec_bits;
			fl_c    = dec_c;
		end
		unique case (fl_c)
			3'd1: fl_aligned = fl_bits << 18;
			3'd2: fl_aligned = fl_bits << 12;
			3'd3: fl_aligned = fl_bits << 6;
			default: fl_aligned = fl_bits;
		endcase
		unique case (fl_c)
			3'd2: fl_n = 3'd1;
			3'd3: fl_n = 3'd2;
			3'd4: fl_n = 3'd3;
			default: fl_n = 3'd0;
		endcase
		for (int k = 0; k < 3; k++) begin
			fl_chars[k] = fl_aligned[23-8*k -: 8];
		end
		fl_chars[3] = 8'd0;
	end

	always_comb begin
		grp_n    = grp_q;
		cnt_n    = cnt_q;
		ended_n  = ended_q;
		push     = 1'b0;
		push_job = '0;
		if (!dir_q) begin
			if (enc_fire) begin
				push           = in_fire;
				push_job.chars = enc_chars;
				push_job.n_m1  = 2'd3;
				push_job.last  = last;
				grp_n          = '0;
				cnt_n          = '0;
			end else begin
				grp_n = enc_bits;
				cnt_n = enc_c[1:0];
			end
		end else if (ended_q) begin
			if (last) begin
				ended_n = 1'b0;
				grp_n   = '0;
				cnt_n   = '0;
			end
		end else if (is_pad) begin
			push           = in_fire && (fl_n != 3'd0);
			push_job.chars = fl_chars;
			push_job.n_m1  = 2'(fl_n - 3'd1);
			push_job.last  = 1'b1;
			grp_n          = '0;
			cnt_n          = '0;
			ended_n        = !last;
		end else if (dec_c == 3'd4 || last) begin
			push           = in_fire && (fl_n != 3'd0);
			push_job.chars = fl_chars;
			push_job.n_m1  = 2'(fl_n - 3'd1);
			push_job.last  = last;
			grp_n          = '0;
			cnt_n          = '0;
		end else begin
			grp_n = dec_bits;
			cnt_n = dec_c[1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dir_q     <= 1'b0;
			variant_q <= 3'd0;
			pad_q     <= PAD_RESET;
			grp_q     <= '0;
			cnt_q     <= '0;
			ended_q   <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_DIRECTION: begin
					dir_q   <= cfg_data[0];
					grp_q   <= '0;
					cnt_q   <= '0;
					ended_q <= 1'b0;
				end
				REG_ALPHABET: variant_q <= cfg_data[2:0];
				REG_PAD:      pad_q     <= cfg_data;
				default: ;
			endcase
		end else if (in_fire) begin
			grp_q   <= grp_n;
			cnt_q   <= cnt_n;
			ended_q <= ended_n;
		end
	end

endmodule

// ===== sv/b64sc_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64sc_queue: short group queue between front end and serializer
// A small circular buffer of group transactions; the head is presented
// directly to the serializer.
// ----------------------------------------------------------------------------
module b64sc_queue
	import b64sc_pkg::*;
#(
	parameter int DEPTH = 2
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t push_job,
	input  logic pop,
	output logic head_valid,
	output job_t head_job,
	output logic full
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	job_t             mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;

	assign head_valid = (cnt_q != '0);
	assign full       = (cnt_q == CNT_W'(DEPTH));
	assign head_job   = mem_q[rd_ptr_q];

	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// ===== sv/b64sc_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64sc_back: result serializer
// Walks through the bytes of the group at the queue head, one result
// transaction per cycle unless stalled; the group goes after its final byte.
// ----------------------------------------------------------------------------
module b64sc_back
	import b64sc_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      head_valid,
	input  job_t      head_job,
	output logic      pop,
	output logic      out_valid,
	output out_item_t out_data,
	input  logic      out_stall
);

	logic [1:0] idx_q;
	logic       at_end;
	logic       out_fire;

	assign at_end             = (idx_q == head_job.n_m1);
	assign out_valid          = head_valid;
	assign out_data.out_byte  = head_job.chars[idx_q];
	assign out_data.out_last  = head_job.last && at_end;
	assign out_fire           = out_valid && !out_stall;
	assign pop                = out_fire && at_end;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (out_fire) begin
			idx_q <= at_end ? 2'd0 : idx_q + 2'd1;
		end
	end

endmodule

// ===== sv/base64_stream_codec_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// base64_stream_codec_top: streaming Base64 encoder and decoder
// Front end, group queue and result serializer of the codec.
// ----------------------------------------------------------------------------
// The codec takes one input transaction per cycle while its group queue
// has room and delivers one result transaction per cycle while out_stall
// is low; the serializer's single output port sets the sustained rate, so
// encoding accepts three bytes per four characters delivered and decoding
// keeps up with one character per cycle. A group's results are written
// to the queue when the item completing it is accepted, and the queue holds
// QUEUE_DEPTH groups so the input side keeps running while results wait.
// Configuration writes take effect at once and are meant for idle periods;
// writing the direction register also discards any partial group.
module base64_stream_codec_top
	import b64sc_pkg::*;
#(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	input  logic                   in_valid,
	input  in_item_t               in_data,
	output logic                   in_stall,
	output logic                   out_valid,
	output out_item_t              out_data,
	input  logic                   out_stall
);

	logic push, pop, head_valid, q_full;
	job_t push_job, head_job;

	assign in_stall = q_full;

	b64sc_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.in_valid (in_valid),
		.in_data  (in_data),
		.q_full   (q_full),
		.push     (push),
		.push_job (push_job)
	);

	b64sc_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_job  (push_job),
		.pop       (pop),
		.head_valid(head_valid),
		.head_job  (head_job),
		.full      (q_full)
	);

	b64sc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head_valid(head_valid),
		.head_job  (head_job),
		.pop       (pop),
		.out_valid (out_valid),
		.out_data  (out_data),
		.out_stall (out_stall)
	);

endmodule

// ===== sv/b64sc_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64sc_checker: port-level checks of the Base64 stream codec
// Watches the top level's ports and flags handshake and flow slips.
// ----------------------------------------------------------------------------
module b64sc_checker
	import b64sc_pkg::*;
(
	input logic      clk,
	input logic      arst_n,
	input logic      in_valid,
	input logic      in_stall,
	input logic      out_valid,
	input out_item_t out_data,
	input logic      out_stall
);

	// A stalled result holds until it is taken.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");

	// Coming out of reset the queue is empty.
	a_reset_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(arst_n) |-> !out_valid && !in_stall)
		else $error("queue not empty after reset");

	// A full queue always has a result on offer.
	a_stall_has_out: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid)
		else $error("input stalled with no result pending");

	// The queue only fills after an input transaction.
	a_stall_rise: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(in_stall) |-> $past(in_valid && !in_stall))
		else $error("input stall rose without an accepted input");

endmodule

bind base64_stream_codec_top b64sc_checker u_b64sc_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_valid (in_valid),
	.in_stall (in_stall),
	.out_valid(out_valid),
	.out_data (out_data),
	.out_stall(out_stall)
);
